[src/miou_pkg.sv]
// ----------------------------------------------------------------------------
// miou_pkg
// shared types and constants of the masked iou accumulator
// ----------------------------------------------------------------------------
package miou_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 25;
  localparam int FRAC_W  = 16;
  localparam int RATIO_W = FRAC_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W = $clog2(RATIO_W);

  localparam longint unsigned COUNT_MAX     = (64'd1 << COUNT_W) - 64'd1;
  localparam longint unsigned MAX_CELLS_DEF = 64'd16777216;

  localparam logic [CFG_IDX_W-1:0] CFG_FILL_A        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_A_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_B        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_B_ENABLE = 2'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[src/miou_div.sv]
// ----------------------------------------------------------------------------
// miou_div
// restoring divider, one quotient bit per cycle on a shared subtractor
// ----------------------------------------------------------------------------
module miou_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  miou_pkg::div_ctrl_t              ctrl,
  input  logic [miou_pkg::COUNT_W-1:0]     dividend,
  input  logic [miou_pkg::COUNT_W-1:0]     divisor,
  output miou_pkg::div_stat_t              stat,
  output logic [miou_pkg::RATIO_W-1:0]     quotient
);

  localparam int RemW = miou_pkg::COUNT_W + 1;
  localparam logic [miou_pkg::STEP_W-1:0] LastStep = miou_pkg::STEP_W'(miou_pkg::RATIO_W - 1);

  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [miou_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [RemW-1:0]               rem_r, rem_nxt;
  logic [miou_pkg::COUNT_W-1:0]  div_r, div_nxt;
  logic [miou_pkg::RATIO_W-1:0]  quo_r, quo_nxt;
  logic [RemW:0]                 diff;
  logic                          ge;
  logic [RemW-1:0]               rem_keep;

  // shared subtract and compare
  assign diff     = {1'b0, rem_r} - {2'b00, div_r};
  assign ge       = ~diff[RemW];
  assign rem_keep = ge ? diff[RemW-1:0] : rem_r;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (ctrl.start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      rem_nxt  = {1'b0, dividend};
      div_nxt  = divisor;
      quo_nxt  = '0;
    end else if (run_r) begin
      quo_nxt = {quo_r[miou_pkg::RATIO_W-2:0], ge};
      rem_nxt = {rem_keep[RemW-2:0], 1'b0};
      if (step_r == LastStep) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

[src/masked_iou_accumulator.sv]
// ----------------------------------------------------------------------------
// masked_iou_accumulator
// binary mask intersection over union counted one grid cell at a time
// ----------------------------------------------------------------------------
// An ordinary cell is taken while busy stays low, so cells can follow back
// to back. A last cell whose union is nonzero raises busy while the ratio
// comes from a 17-step restoring division on one shared subtractor, one
// quotient bit per cycle. A last cell with an empty union gives its result
// in the next cycle without raising busy. Each result is on the out_ ports
// for exactly one cycle with out_valid high; the receiver cannot stall, so it
// must take every transfer. The user must write fill registers through the
// cfg_ channel only while no grid is in flight; the block does not enforce it.
module masked_iou_accumulator #(
  parameter longint unsigned MAX_CELLS = miou_pkg::MAX_CELLS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [miou_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [miou_pkg::VALUE_W-1:0]          cfg_data,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [miou_pkg::VALUE_W-1:0]   in_value_a,
  input  logic                                  in_missing_a,
  input  logic signed [miou_pkg::VALUE_W-1:0]   in_value_b,
  input  logic                                  in_missing_b,
  input  logic                                  in_last_cell,
  output logic                                  out_valid,
  output logic [miou_pkg::COUNT_W-1:0]          out_intersection_count,
  output logic [miou_pkg::COUNT_W-1:0]          out_union_count,
  output logic [miou_pkg::RATIO_W-1:0]          out_iou_ratio,
  output logic                                  out_iou_undefined
);

  localparam logic [miou_pkg::COUNT_W-1:0] CountCap =
    (MAX_CELLS < miou_pkg::COUNT_MAX) ? miou_pkg::COUNT_W'(MAX_CELLS)
                                      : miou_pkg::COUNT_W'(miou_pkg::COUNT_MAX);

  logic signed [miou_pkg::VALUE_W-1:0] fill_a_r, fill_b_r;
  logic                                fill_a_en_r, fill_b_en_r;

  miou_pkg::state_t             state_r, state_nxt;
  logic [miou_pkg::COUNT_W-1:0] both_r, both_nxt;
  logic [miou_pkg::COUNT_W-1:0] either_r, either_nxt;
  logic [miou_pkg::COUNT_W-1:0] res_inter_r, res_inter_nxt;
  logic [miou_pkg::COUNT_W-1:0] res_union_r, res_union_nxt;
  logic [miou_pkg::RATIO_W-1:0] res_ratio_r, res_ratio_nxt;
  logic                         res_undef_r, res_undef_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic                         accept;
  logic                         skip_a, skip_b, pos_a, pos_b, cell_ok;
  logic [miou_pkg::COUNT_W-1:0] both_upd, either_upd;

  miou_pkg::div_ctrl_t          div_ctrl;
  miou_pkg::div_stat_t          div_stat;
  logic [miou_pkg::RATIO_W-1:0] div_quo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_a_r    <= '0;
      fill_a_en_r <= 1'b0;
      fill_b_r    <= '0;
      fill_b_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        miou_pkg::CFG_FILL_A:        fill_a_r    <= cfg_data;
        miou_pkg::CFG_FILL_A_ENABLE: fill_a_en_r <= cfg_data[0];
        miou_pkg::CFG_FILL_B:        fill_b_r    <= cfg_data;
        miou_pkg::CFG_FILL_B_ENABLE: fill_b_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy   = (state_r != miou_pkg::ST_IDLE);
  assign accept = start && !busy;

  // cell classification
  assign skip_a  = in_missing_a || (fill_a_en_r && (in_value_a == fill_a_r));
  assign skip_b  = in_missing_b || (fill_b_en_r && (in_value_b == fill_b_r));
  assign pos_a   = (in_value_a != '0) && !in_value_a[miou_pkg::VALUE_W-1];
  assign pos_b   = (in_value_b != '0) && !in_value_b[miou_pkg::VALUE_W-1];
  assign cell_ok = !skip_a && !skip_b;

  always_comb begin
    both_upd   = both_r;
    either_upd = either_r;
    if (cell_ok && pos_a && pos_b && (both_r < CountCap)) begin
      both_upd = both_r + 1'b1;
    end
    if (cell_ok && (pos_a || pos_b) && (either_r < CountCap)) begin
      either_upd = either_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    both_nxt       = both_r;
    either_nxt     = either_r;
    res_inter_nxt  = res_inter_r;
    res_union_nxt  = res_union_r;
    res_ratio_nxt  = res_ratio_r;
    res_undef_nxt  = res_undef_r;
    out_valid_nxt  = 1'b0;
    div_ctrl.start = 1'b0;
    case (state_r)
      miou_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_last_cell) begin
            both_nxt      = '0;
            either_nxt    = '0;
            res_inter_nxt = both_upd;
            res_union_nxt = either_upd;
            if (either_upd == '0) begin
              res_ratio_nxt = '0;
              res_undef_nxt = 1'b1;
              out_valid_nxt = 1'b1;
            end else begin
              res_undef_nxt  = 1'b0;
              div_ctrl.start = 1'b1;
              state_nxt      = miou_pkg::ST_DIVIDE;
            end
          end else begin
            both_nxt   = both_upd;
            either_nxt = either_upd;
          end
        end
      end
      miou_pkg::ST_DIVIDE: begin
        if (div_stat.done) begin
          res_ratio_nxt = div_quo;
          out_valid_nxt = 1'b1;
          state_nxt     = miou_pkg::ST_IDLE;
        end
      end
      default: state_nxt = miou_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= miou_pkg::ST_IDLE;
      both_r      <= '0;
      either_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      both_r      <= both_nxt;
      either_r    <= either_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_inter_r <= res_inter_nxt;
    res_union_r <= res_union_nxt;
    res_ratio_r <= res_ratio_nxt;
    res_undef_r <= res_undef_nxt;
  end

  miou_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (both_upd),
    .divisor  (either_upd),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign out_valid              = out_valid_r;
  assign out_intersection_count = res_inter_r;
  assign out_union_count        = res_union_r;
  assign out_iou_ratio          = res_ratio_r;
  assign out_iou_undefined      = res_undef_r;

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result transfer while busy");

  a_div_only_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == miou_pkg::ST_DIVIDE))
    else $error("divider running outside divide state");

  a_inter_le_union: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_intersection_count <= out_union_count))
    else $error("intersection exceeds union");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_iou_ratio <= miou_pkg::RATIO_W'(1 << miou_pkg::FRAC_W)))
    else $error("ratio above one");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_iou_undefined) |-> (out_iou_ratio == '0) && (out_union_count == '0))
    else $error("undefined ratio with nonzero fields");

  a_busy_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(accept && in_last_cell))
    else $error("busy raised without a last cell");

endmodule

[tb/sv/masked_iou_accumulator_tb.sv]
// ----------------------------------------------------------------------------
// masked_iou_accumulator_tb
// self-checking bench for the masked iou accumulator: a directed table of
// cells and fill settings, then random grids under random fill settings,
// each result compared field by field with the pinned expectation of its row
// or else with a cycle-free model of the counts
module masked_iou_accumulator_tb;

  typedef struct packed {
    logic [miou_pkg::COUNT_W-1:0] inter;
    logic [miou_pkg::COUNT_W-1:0] uni;
    logic [miou_pkg::RATIO_W-1:0] ratio;
    logic                         undef;
  } iou_result_t;

  typedef enum logic {
    ROW_CELL,
    ROW_FILLS
  } row_kind_t;

  // for fill rows: a/b carry the fill values, ma/mb the enables
  typedef struct packed {
    row_kind_t                    kind;
    logic [miou_pkg::VALUE_W-1:0] a;
    logic                         ma;
    logic [miou_pkg::VALUE_W-1:0] b;
    logic                         mb;
    logic                         last;
    logic                         pin;
    iou_result_t                  want;
  } step_row_t;

  localparam iou_result_t NONE = '0;
  localparam longint unsigned CELL_CAP =
    (miou_pkg::MAX_CELLS_DEF < miou_pkg::COUNT_MAX) ? miou_pkg::MAX_CELLS_DEF
                                                    : miou_pkg::COUNT_MAX;
  localparam int N_ROWS = 25;
  localparam int N_ITEMS = 1400;
  localparam int SETTLE = 24;

  localparam step_row_t SCRIPT [N_ROWS] = '{
    '{ROW_CELL,  32'h00000005, 1'b1, 32'h00000009, 1'b0, 1'b1, 1'b1, '{25'd0, 25'd0, 17'd0, 1'b1}},
    '{ROW_CELL,  32'h7FFFFFFF, 1'b0, 32'h7FFFFFFF, 1'b0, 1'b1, 1'b1, '{25'd1, 25'd1, 17'd65536, 1'b0}},
    '{ROW_CELL,  32'h80000000, 1'b0, 32'h00000001, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000000, 1'b0, 32'h00000000, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000005, 1'b0, 32'h00000007, 1'b1, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000001, 1'b0, 32'h00000002, 1'b0, 1'b1, 1'b1, '{25'd1, 25'd2, 17'd32768, 1'b0}},
    '{ROW_CELL,  32'h00000003, 1'b0, 32'h00000003, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000000, 1'b0, 32'h00000009, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000009, 1'b0, 32'hFFFFFFFC, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000000, 1'b0, 32'h00000000, 1'b0, 1'b1, 1'b1, '{25'd1, 25'd3, 17'd21845, 1'b0}},
    '{ROW_CELL,  32'hFFFFFFFB, 1'b1, 32'h00000000, 1'b1, 1'b1, 1'b1, '{25'd0, 25'd0, 17'd0, 1'b1}},
    '{ROW_FILLS, 32'h80000000, 1'b1, 32'h7FFFFFFF, 1'b1, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h80000000, 1'b0, 32'h00000005, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000005, 1'b0, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h7FFFFFFF, 1'b0, 32'h80000000, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000004, 1'b1, 32'h00000004, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000006, 1'b0, 32'h00000006, 1'b0, 1'b1, 1'b1, '{25'd1, 25'd2, 17'd32768, 1'b0}},
    '{ROW_FILLS, 32'h7FFFFFFF, 1'b0, 32'h80000000, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h7FFFFFFF, 1'b0, 32'h80000000, 1'b0, 1'b1, 1'b1, '{25'd0, 25'd1, 17'd0, 1'b0}},
    '{ROW_FILLS, 32'h00000000, 1'b1, 32'h00000000, 1'b1, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000000, 1'b0, 32'h00000005, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000005, 1'b0, 32'h00000000, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'hFFFFFFFF, 1'b0, 32'h00000003, 1'b0, 1'b0, 1'b0, NONE},
    '{ROW_CELL,  32'h00000002, 1'b0, 32'h00000002, 1'b0, 1'b1, 1'b0, NONE}
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [miou_pkg::CFG_IDX_W-1:0] cfg_index = miou_pkg::CFG_FILL_A;
  logic [miou_pkg::VALUE_W-1:0]   cfg_data = '0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [miou_pkg::VALUE_W-1:0]   in_value_a = '0;
  logic                           in_missing_a = 1'b0;
  logic [miou_pkg::VALUE_W-1:0]   in_value_b = '0;
  logic                           in_missing_b = 1'b0;
  logic                           in_last_cell = 1'b0;
  logic                           out_valid;
  logic [miou_pkg::COUNT_W-1:0]   out_intersection_count;
  logic [miou_pkg::COUNT_W-1:0]   out_union_count;
  logic [miou_pkg::RATIO_W-1:0]   out_iou_ratio;
  logic                           out_iou_undefined;

  // typed expectation riding along with the cell it belongs to
  logic                           pin_on = 1'b0;
  iou_result_t                    pin_want = NONE;

  logic [miou_pkg::VALUE_W-1:0]   shadow_fill_a = '0;
  logic                           shadow_a_en = 1'b0;
  logic [miou_pkg::VALUE_W-1:0]   shadow_fill_b = '0;
  logic                           shadow_b_en = 1'b0;
  longint unsigned                both_cnt = 0;
  longint unsigned                either_cnt = 0;

  iou_result_t                    pending_iou [$];
  int                             mismatches = 0;
  int                             items_sent = 0;
  bit                             calm = 1'b0;
  logic [miou_pkg::VALUE_W-1:0]   cur_fill_a = '0;
  logic [miou_pkg::VALUE_W-1:0]   cur_fill_b = '0;

  masked_iou_accumulator uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .start                  (start),
    .busy                   (busy),
    .in_value_a             (in_value_a),
    .in_missing_a           (in_missing_a),
    .in_value_b             (in_value_b),
    .in_missing_b           (in_missing_b),
    .in_last_cell           (in_last_cell),
    .out_valid              (out_valid),
    .out_intersection_count (out_intersection_count),
    .out_union_count        (out_union_count),
    .out_iou_ratio          (out_iou_ratio),
    .out_iou_undefined      (out_iou_undefined)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10000000;
    $display("masked_iou_accumulator verification failed");
    $finish;
  end

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic bit tally_cell(input logic [miou_pkg::VALUE_W-1:0] a, input logic ma,
                                    input logic [miou_pkg::VALUE_W-1:0] b, input logic mb,
                                    input logic last, output iou_result_t res);
    bit skip_a;
    bit skip_b;
    bit pos_a;
    bit pos_b;
    longint unsigned q;
    skip_a = ma || (shadow_a_en && a == shadow_fill_a);
    skip_b = mb || (shadow_b_en && b == shadow_fill_b);
    if (!skip_a && !skip_b) begin
      pos_a = (a != '0) && !a[miou_pkg::VALUE_W-1];
      pos_b = (b != '0) && !b[miou_pkg::VALUE_W-1];
      if (pos_a && pos_b && both_cnt < CELL_CAP) both_cnt++;
      if ((pos_a || pos_b) && either_cnt < CELL_CAP) either_cnt++;
    end
    res = NONE;
    if (!last) return 1'b0;
    res.inter = both_cnt[miou_pkg::COUNT_W-1:0];
    res.uni = either_cnt[miou_pkg::COUNT_W-1:0];
    if (either_cnt != 0) begin
      q = (both_cnt << miou_pkg::FRAC_W) / either_cnt;
      if (q > (64'd1 << miou_pkg::FRAC_W)) q = 64'd1 << miou_pkg::FRAC_W;
      res.ratio = q[miou_pkg::RATIO_W-1:0];
      res.undef = 1'b0;
    end else begin
      res.ratio = '0;
      res.undef = 1'b1;
    end
    both_cnt = 0;
    either_cnt = 0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    iou_result_t want;
    iou_result_t calc;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_iou.size() == 0) begin
          note_mismatch("result with nothing pending");
        end else begin
          want = pending_iou.pop_front();
          if (out_intersection_count !== want.inter)
            note_mismatch($sformatf("intersection %0d, want %0d",
                                    out_intersection_count, want.inter));
          if (out_union_count !== want.uni)
            note_mismatch($sformatf("union %0d, want %0d", out_union_count, want.uni));
          if (out_iou_ratio !== want.ratio)
            note_mismatch($sformatf("ratio %0d, want %0d", out_iou_ratio, want.ratio));
          if (out_iou_undefined !== want.undef)
            note_mismatch($sformatf("undefined %0b, want %0b",
                                    out_iou_undefined, want.undef));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          miou_pkg::CFG_FILL_A:        shadow_fill_a <= cfg_data;
          miou_pkg::CFG_FILL_A_ENABLE: shadow_a_en <= cfg_data[0];
          miou_pkg::CFG_FILL_B:        shadow_fill_b <= cfg_data;
          miou_pkg::CFG_FILL_B_ENABLE: shadow_b_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (tally_cell(in_value_a, in_missing_a, in_value_b, in_missing_b,
                       in_last_cell, calc))
          pending_iou.insert(pending_iou.size(), pin_on ? pin_want : calc);
      end
    end
  end

  task automatic send_cell(input logic [miou_pkg::VALUE_W-1:0] a, input logic ma,
                           input logic [miou_pkg::VALUE_W-1:0] b, input logic mb,
                           input logic last, input logic pin, input iou_result_t want);
    int gap;
    if (!calm && $urandom_range(99) < 11) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      in_value_a <= $urandom;
      in_value_b <= $urandom;
      in_missing_a <= 1'($urandom_range(1));
      in_missing_b <= 1'($urandom_range(1));
      in_last_cell <= 1'($urandom_range(1));
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_value_a <= a;
    in_missing_a <= ma;
    in_value_b <= b;
    in_missing_b <= mb;
    in_last_cell <= last;
    pin_on <= pin;
    pin_want <= want;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic write_reg(input logic [miou_pkg::CFG_IDX_W-1:0] idx,
                           input logic [miou_pkg::VALUE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if ($urandom_range(99) < 11) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // only between grids: drain, let the divider settle, then write all four
  task automatic set_fills(input logic [miou_pkg::VALUE_W-1:0] fa, input logic ea,
                           input logic [miou_pkg::VALUE_W-1:0] fb, input logic eb);
    start <= 1'b0;
    while (pending_iou.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(miou_pkg::CFG_FILL_A, fa);
    write_reg(miou_pkg::CFG_FILL_A_ENABLE, {{(miou_pkg::VALUE_W-1){1'b0}}, ea});
    write_reg(miou_pkg::CFG_FILL_B, fb);
    write_reg(miou_pkg::CFG_FILL_B_ENABLE, {{(miou_pkg::VALUE_W-1){1'b0}}, eb});
    cfg_valid <= 1'b0;
    cur_fill_a = fa;
    cur_fill_b = fb;
  endtask

  function automatic logic [miou_pkg::VALUE_W-1:0] pick_extreme();
    case ($urandom_range(3))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'h00000000;
      default: return 32'hFFFFFFFF;
    endcase
  endfunction

  function automatic logic [miou_pkg::VALUE_W-1:0] pick_value(
      input logic [miou_pkg::VALUE_W-1:0] fill);
    int r;
    r = $urandom_range(99);
    if (r < 20) return fill;
    if (r < 55) return miou_pkg::VALUE_W'($signed($urandom_range(6)) - 3);
    if (r < 62) return pick_extreme();
    return $urandom;
  endfunction

  initial begin : stimulus
    int grid_no;
    int len;
    int k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      if (SCRIPT[i].kind == ROW_FILLS)
        set_fills(SCRIPT[i].a, SCRIPT[i].ma, SCRIPT[i].b, SCRIPT[i].mb);
      else
        send_cell(SCRIPT[i].a, SCRIPT[i].ma, SCRIPT[i].b, SCRIPT[i].mb,
                  SCRIPT[i].last, SCRIPT[i].pin, SCRIPT[i].want);
    end

    grid_no = 0;
    while (items_sent < N_ITEMS + N_ROWS) begin
      if (grid_no % 6 == 5)
        set_fills(($urandom_range(1) != 0) ? pick_extreme() : pick_value($urandom),
                  1'($urandom_range(1)),
                  ($urandom_range(1) != 0) ? pick_extreme() : pick_value($urandom),
                  1'($urandom_range(1)));
      len = ($urandom_range(99) < 5) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      for (k = 0; k < len; k++) begin
        calm = (items_sent >= 600 && items_sent < 900);
        send_cell(pick_value(cur_fill_a), $urandom_range(99) < 8,
                  pick_value(cur_fill_b), $urandom_range(99) < 8,
                  k == len - 1, 1'b0, NONE);
      end
      grid_no++;
    end

    start <= 1'b0;
    while (pending_iou.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("masked_iou_accumulator verification clean");
    else
      $display("masked_iou_accumulator verification failed");
    $finish;
  end

endmodule

[filelist.f]
src/miou_pkg.sv
src/miou_div.sv
src/masked_iou_accumulator.sv
tb/sv/masked_iou_accumulator_tb.sv
